// ===== rtl/cidrt_pkg.sv =====
`default_nettype none

package cidrt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BOOT_HOLD = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_BOOT_ID   = 1'b0;
    localparam logic REG_CPU_LIMIT = 1'b1;

    localparam int ID_W    = 8;
    localparam int LIMIT_W = 7;
    localparam int CPU_W   = 6;

endpackage

`default_nettype wire

// ===== rtl/cpu_id_registration_table_unit.sv =====
// A request is looked up by the slot search, which reads one table entry per cycle from the
// slot RAM; a new request is accepted only after the previous result has been registered.
// The next request is taken while the previous result still waits on the output.
// Reset: rst_n is asynchronous and active low; all slots read as invalid straight after
// reset, with no clearing pass, and the registers return to boot ID 0 and limit 64.
`default_nettype none

module cpu_id_registration_table_unit #(
    parameter int MAX_SLOTS = 64,
    parameter int ID_SPACE  = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] apic_id
    input  wire logic        s_tuser,   // [0] enabled

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [5:0] logical_cpu, [13:6] highest_apic_id, [15:14] zero
    output logic      [1:0]  m_tuser    // [1:0] status
);

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int LIM_W  = ((CNT_W > cidrt_pkg::LIMIT_W) ? CNT_W : cidrt_pkg::LIMIT_W) + 1;
    localparam int PRES_N = (ID_SPACE < 256) ? ID_SPACE : 256;
    localparam int PRES_W = $clog2(PRES_N);

    cidrt_pkg::state_t state_reg, state_next;

    logic [cidrt_pkg::ID_W-1:0]    boot_id_reg, boot_id_next;
    logic [cidrt_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    logic [CNT_W-1:0]     alloc_reg, alloc_next;
    logic [CNT_W-1:0]     en_cnt_reg, en_cnt_next;
    logic [MAX_SLOTS-1:0] slot_vld_reg, slot_vld_next;
    logic [PRES_N-1:0]    present_reg, present_next;
    logic [cidrt_pkg::ID_W-1:0] max_id_reg, max_id_next;

    logic [cidrt_pkg::ID_W-1:0] req_id_reg, req_id_next;
    logic                       req_en_reg, req_en_next;

    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic              chk_vld_reg, chk_vld_next;

    cidrt_pkg::status_t res_status_reg, res_status_next;
    logic [SLOT_W-1:0]  res_cpu_reg, res_cpu_next;
    logic               res_new_reg, res_new_next;
    logic               res_alloc_reg, res_alloc_next;

    logic                       m_valid_reg, m_valid_next;
    cidrt_pkg::status_t         m_status_reg, m_status_next;
    logic [cidrt_pkg::CPU_W-1:0] m_cpu_reg, m_cpu_next;
    logic [cidrt_pkg::ID_W-1:0]  m_high_reg, m_high_next;

    logic [SLOT_W-1:0]          ram_raddr;
    logic [cidrt_pkg::ID_W-1:0] ram_rdata;
    logic                       ram_we;

    logic             in_accept;
    logic             cfg_write;
    logic             out_free;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] en_cnt_w;
    logic [LIM_W-1:0] alloc_w;
    logic             boot_in_range;
    logic             boot_present;
    logic             near_limit;
    logic             at_limit;
    logic             issue_more;
    logic             hit;
    logic             search_done;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            cidrt_pkg::REG_BOOT_ID:   prdata = 32'(boot_id_reg);
            cidrt_pkg::REG_CPU_LIMIT: prdata = 32'(limit_reg);
            default:                  prdata = '0;
        endcase
    end

    // A limit above the table depth behaves as the depth.
    assign lim = (LIM_W'(limit_reg) > LIM_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS)
                                                          : LIM_W'(limit_reg);
    assign en_cnt_w = LIM_W'(en_cnt_reg);
    assign alloc_w  = LIM_W'(alloc_reg);

    assign boot_in_range = (9'(boot_id_reg) < 9'(PRES_N));
    assign boot_present  = boot_in_range && present_reg[boot_id_reg[PRES_W-1:0]];
    assign near_limit    = !boot_present && ((en_cnt_w + LIM_W'(1)) >= lim)
                           && (req_id_reg != boot_id_reg);
    assign at_limit      = (en_cnt_w >= lim);

    assign issue_more  = (iss_reg < alloc_reg);
    assign hit         = chk_vld_reg && slot_vld_reg[chk_idx_reg] && (ram_rdata == req_id_reg);
    assign search_done = !chk_vld_reg && !issue_more;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cidrt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = cidrt_pkg::ST_EVAL;
                end
            end
            cidrt_pkg::ST_EVAL:
            begin
                if (near_limit || at_limit || (req_id_reg == boot_id_reg))
                begin
                    state_next = cidrt_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = cidrt_pkg::ST_SEARCH;
                end
            end
            cidrt_pkg::ST_SEARCH:
            begin
                if (hit || search_done)
                begin
                    state_next = cidrt_pkg::ST_FINISH;
                end
            end
            cidrt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cidrt_pkg::ST_IDLE;
                end
            end
            default: state_next = cidrt_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = iss_reg[SLOT_W-1:0];
        unique case (state_reg)
            cidrt_pkg::ST_IDLE:   s_tready = 1'b1;
            cidrt_pkg::ST_EVAL:   ram_raddr = '0;
            cidrt_pkg::ST_SEARCH: ram_raddr = iss_reg[SLOT_W-1:0];
            cidrt_pkg::ST_FINISH:
            begin
                ram_we = out_free && (res_status_reg == cidrt_pkg::STATUS_OK) && res_new_reg;
            end
            default:              s_tready = 1'b0;
        endcase
    end

    // Datapath
    always_comb
    begin
        boot_id_next    = boot_id_reg;
        limit_next      = limit_reg;
        alloc_next      = alloc_reg;
        en_cnt_next     = en_cnt_reg;
        slot_vld_next   = slot_vld_reg;
        present_next    = present_reg;
        max_id_next     = max_id_reg;
        req_id_next     = req_id_reg;
        req_en_next     = req_en_reg;
        iss_next        = iss_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        res_status_next = res_status_reg;
        res_cpu_next    = res_cpu_reg;
        res_new_next    = res_new_reg;
        res_alloc_next  = res_alloc_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_cpu_next      = m_cpu_reg;
        m_high_next     = m_high_reg;

        if (cfg_write)
        begin
            unique case (paddr[2])
                cidrt_pkg::REG_BOOT_ID:   boot_id_next = pwdata[cidrt_pkg::ID_W-1:0];
                cidrt_pkg::REG_CPU_LIMIT: limit_next   = pwdata[cidrt_pkg::LIMIT_W-1:0];
                default:                  limit_next   = limit_reg;
            endcase
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            cidrt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_id_next = s_tdata;
                    req_en_next = s_tuser;
                end
            end
            cidrt_pkg::ST_EVAL:
            begin
                iss_next        = '0;
                chk_vld_next    = 1'b0;
                res_cpu_next    = '0;
                res_new_next    = 1'b0;
                res_alloc_next  = 1'b0;
                res_status_next = cidrt_pkg::STATUS_OK;
                if (near_limit)
                begin
                    res_status_next = cidrt_pkg::STATUS_BOOT_HOLD;
                end
                else if (at_limit)
                begin
                    res_status_next = cidrt_pkg::STATUS_FULL;
                end
                else if (req_id_reg == boot_id_reg)
                begin
                    // The boot processor always lands in slot zero.
                    res_new_next = 1'b1;
                end
            end
            cidrt_pkg::ST_SEARCH:
            begin
                chk_vld_next = issue_more;
                chk_idx_next = iss_reg[SLOT_W-1:0];
                if (issue_more)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    res_status_next = cidrt_pkg::STATUS_OK;
                    res_cpu_next    = chk_idx_reg;
                end
                else if (search_done)
                begin
                    if (alloc_w >= lim)
                    begin
                        res_status_next = cidrt_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        res_status_next = cidrt_pkg::STATUS_OK;
                        res_cpu_next    = alloc_reg[SLOT_W-1:0];
                        res_new_next    = 1'b1;
                        res_alloc_next  = 1'b1;
                    end
                end
            end
            cidrt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_cpu_next    = '0;
                    m_high_next   = max_id_reg;
                    if (res_status_reg == cidrt_pkg::STATUS_OK)
                    begin
                        m_cpu_next = cidrt_pkg::CPU_W'(res_cpu_reg);
                        if (req_id_reg > max_id_reg)
                        begin
                            max_id_next = req_id_reg;
                            m_high_next = req_id_reg;
                        end
                        if (res_new_reg)
                        begin
                            slot_vld_next[res_cpu_reg] = 1'b1;
                        end
                        if (res_alloc_reg)
                        begin
                            alloc_next = alloc_reg + CNT_W'(1);
                        end
                        if (req_en_reg)
                        begin
                            en_cnt_next = en_cnt_reg + CNT_W'(1);
                            if (9'(req_id_reg) < 9'(PRES_N))
                            begin
                                present_next[req_id_reg[PRES_W-1:0]] = 1'b1;
                            end
                        end
                    end
                end
            end
            default: m_valid_next = m_valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cidrt_pkg::ST_IDLE;
            boot_id_reg  <= '0;
            limit_reg    <= cidrt_pkg::LIMIT_W'(64);
            alloc_reg    <= CNT_W'(1);
            en_cnt_reg   <= '0;
            slot_vld_reg <= '0;
            present_reg  <= '0;
            max_id_reg   <= '0;
            iss_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            boot_id_reg  <= boot_id_next;
            limit_reg    <= limit_next;
            alloc_reg    <= alloc_next;
            en_cnt_reg   <= en_cnt_next;
            slot_vld_reg <= slot_vld_next;
            present_reg  <= present_next;
            max_id_reg   <= max_id_next;
            iss_reg      <= iss_next;
            chk_vld_reg  <= chk_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_id_reg     <= req_id_next;
        req_en_reg     <= req_en_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_cpu_reg    <= res_cpu_next;
        res_new_reg    <= res_new_next;
        res_alloc_reg  <= res_alloc_next;
        m_status_reg   <= m_status_next;
        m_cpu_reg      <= m_cpu_next;
        m_high_reg     <= m_high_next;
    end

    cidrt_ram #(
        .WIDTH (cidrt_pkg::ID_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (res_cpu_reg),
        .wdata (req_id_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_high_reg, m_cpu_reg};
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

// ===== rtl/cidrt_ram.sv =====
`default_nettype none

module cidrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/cidrt_checker.sv =====
`default_nettype none

module cidrt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // After accepting a request the block holds s_tready low while it works on it.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted on consecutive cycles");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == cidrt_pkg::STATUS_OK) || (m_tuser == cidrt_pkg::STATUS_BOOT_HOLD)
                     || (m_tuser == cidrt_pkg::STATUS_FULL))
        else $error("undefined status code");

    // A refused request carries slot zero.
    a_refused_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != cidrt_pkg::STATUS_OK) |-> (m_tdata[5:0] == 6'd0))
        else $error("refused request reports a slot");

endmodule

bind cpu_id_registration_table_unit cidrt_checker u_cidrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
